// ----- hdl/wosd_pkg.sv -----
// Package for the wheel odometry straight drive unit.
// Holds operation codes, register indexes, field widths and reset values.
// No dependencies.
package wosd_pkg;

    // Operation codes of a sample beat
    typedef enum logic [0:0] {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRIGGER_LEVEL     = 2'd0,
        REG_HYSTERESIS_MARGIN = 2'd1,
        REG_SAVED_CORRECTION  = 2'd2,
        REG_UNUSED            = 2'd3
    } cfg_reg_t;

    // Field widths
    localparam int TRIGGER_W    = 10;
    localparam int MARGIN_W     = 9;
    localparam int CORRECTION_W = 16;
    localparam int SPEED_W      = 8;
    localparam int LED_W        = 2;
    localparam int DIFF_W       = 9;
    localparam int WORD_W       = 9;
    localparam int DISTANCE_W   = 16;

    // Reset values of the configuration registers
    localparam logic [TRIGGER_W-1:0]    TRIGGER_RESET    = 10'd600;
    localparam logic [MARGIN_W-1:0]     MARGIN_RESET     = 9'd10;
    localparam logic [CORRECTION_W-1:0] CORRECTION_RESET = 16'hFFFF;

    // Difference limits and correction word encoding
    localparam logic signed [DIFF_W-1:0] DIFF_MAX       = 9'sd255;
    localparam logic [SPEED_W-1:0]       SPEED_FULL     = 8'd255;
    localparam logic [CORRECTION_W-1:0]  CORR_LIMIT     = 16'd512;
    localparam logic [WORD_W:0]          CORR_OFFSET    = 10'd256;

    // Default parameter values
    localparam int SAVE_INTERVAL_DEF = 128;
    localparam int SAMPLE_BITS_DEF   = 10;

endpackage

// ----- hdl/wosd_if.sv -----
// Valid/ready channel interfaces of the wheel odometry straight drive unit.
// Sample, result and configuration channels; depends on wosd_pkg.
interface wosd_sample_if #(
    parameter int SAMPLE_BITS = wosd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    wosd_pkg::op_t          operation;
    logic [SAMPLE_BITS-1:0] left_level;
    logic [SAMPLE_BITS-1:0] right_level;

    modport source (output valid, output operation, output left_level, output right_level,
                    input ready);
    modport sink (input valid, input operation, input left_level, input right_level,
                  output ready);
endinterface

interface wosd_result_if;
    logic                                valid;
    logic                                ready;
    logic [wosd_pkg::SPEED_W-1:0]        left_speed;
    logic [wosd_pkg::SPEED_W-1:0]        right_speed;
    logic [wosd_pkg::LED_W-1:0]          led_code;
    logic signed [wosd_pkg::DIFF_W-1:0]  wheel_difference;
    logic                                save_request;
    logic [wosd_pkg::WORD_W-1:0]         save_word;

    modport source (output valid, output left_speed, output right_speed, output led_code,
                    output wheel_difference, output save_request, output save_word,
                    input ready);
    modport sink (input valid, input left_speed, input right_speed, input led_code,
                  input wheel_difference, input save_request, input save_word,
                  output ready);
endinterface

interface wosd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wosd_pkg::CFG_INDEX_W-1:0]   index;
    logic [wosd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/wheel_odometry_straight_drive_unit.sv -----
// Top level of the wheel odometry straight drive unit.
// Depends on wosd_pkg and the channel interfaces in wosd_if.sv.
//
// Takes one sample beat per cycle while the result channel is not stalled and
// returns one result beat per sample. Each beat runs both encoder levels
// through hysteresis comparators, steps the clamped wheel difference and the
// distance count, and derives the motor speeds from the difference. A start
// beat reloads the difference from the saved correction word, or zero if it
// is not below CORR_LIMIT. A save request comes with the left edge that
// brings the distance to a multiple of SAVE_INTERVAL. The rate is set by the
// single input register feeding one result register. The user writes
// configuration only while the unit is idle; the unit does not enforce it.
module wheel_odometry_straight_drive_unit #(
    parameter int SAVE_INTERVAL = wosd_pkg::SAVE_INTERVAL_DEF,
    parameter int SAMPLE_BITS   = wosd_pkg::SAMPLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    wosd_sample_if.sink    sample,
    wosd_result_if.source  result,
    wosd_cfg_if.sink       cfg
);
    import wosd_pkg::*;

    localparam int CMP_W = ((SAMPLE_BITS > TRIGGER_W) ? SAMPLE_BITS : TRIGGER_W) + 1;
    localparam int REM_W = (SAVE_INTERVAL > 2) ? $clog2(SAVE_INTERVAL) : 1;
    localparam logic [REM_W:0] REM_WRAP = (REM_W+1)'(SAVE_INTERVAL);
    localparam logic signed [DIFF_W:0] SUM_MAX = 10'sd255;
    localparam logic signed [DIFF_W:0] SUM_MIN = -10'sd255;

    // Configuration registers
    logic [TRIGGER_W-1:0]    trigger_reg;
    logic [MARGIN_W-1:0]     margin_reg;
    logic [CORRECTION_W-1:0] correction_reg;

    // Input register
    logic                   s1_valid_reg;
    op_t                    s1_op_reg;
    logic [SAMPLE_BITS-1:0] s1_left_reg;
    logic [SAMPLE_BITS-1:0] s1_right_reg;

    // Unit state
    logic                     left_phase_reg, left_phase_next;
    logic                     right_phase_reg, right_phase_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [DISTANCE_W-1:0]    dist_reg, dist_next;
    logic [REM_W-1:0]         rem_reg, rem_next;

    // Result register
    logic                     out_valid_reg;
    logic [SPEED_W-1:0]       left_speed_reg, left_speed_next;
    logic [SPEED_W-1:0]       right_speed_reg, right_speed_next;
    logic signed [DIFF_W-1:0] out_diff_reg;
    logic                     save_reg, save_next;
    logic [WORD_W-1:0]        word_reg, word_next;

    logic advance;
    logic fire;

    // Comparator and step signals
    logic [CMP_W-1:0]         left_ext, right_ext, trig_ext, marg_ext, upper;
    logic                     left_edge, right_edge;
    logic signed [DIFF_W:0]   sum;
    logic signed [DIFF_W:0]   load;
    logic [DISTANCE_W-1:0]    dist_inc;
    logic [REM_W:0]           rem_inc;

    assign advance     = !out_valid_reg || result.ready;
    assign fire        = s1_valid_reg && advance;
    assign sample.ready = !s1_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg    <= TRIGGER_RESET;
            margin_reg     <= MARGIN_RESET;
            correction_reg <= CORRECTION_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_TRIGGER_LEVEL:     trigger_reg    <= cfg.data[TRIGGER_W-1:0];
                REG_HYSTERESIS_MARGIN: margin_reg     <= cfg.data[MARGIN_W-1:0];
                REG_SAVED_CORRECTION:  correction_reg <= cfg.data;
                default:               ;
            endcase
        end
    end

    // Compute the next state and the result of the held beat
    always_comb
    begin
        left_ext  = CMP_W'(s1_left_reg);
        right_ext = CMP_W'(s1_right_reg);
        trig_ext  = CMP_W'(trigger_reg);
        marg_ext  = CMP_W'(margin_reg);
        upper     = trig_ext + marg_ext;

        left_edge  = left_phase_reg ? ((left_ext + marg_ext) < trig_ext) : (left_ext > upper);
        right_edge = right_phase_reg ? ((right_ext + marg_ext) < trig_ext) : (right_ext > upper);

        sum      = {diff_reg[DIFF_W-1], diff_reg} + {{DIFF_W{1'b0}}, left_edge}
                   - {{DIFF_W{1'b0}}, right_edge};
        load     = {1'b0, correction_reg[WORD_W-1:0]} - CORR_OFFSET;
        dist_inc = dist_reg + DISTANCE_W'(1);
        rem_inc  = {1'b0, rem_reg} + (REM_W+1)'(1);

        left_phase_next  = left_phase_reg;
        right_phase_next = right_phase_reg;
        diff_next        = diff_reg;
        dist_next        = dist_reg;
        rem_next         = rem_reg;
        save_next        = 1'b0;

        if (s1_op_reg == OP_START)
        begin
            left_phase_next  = 1'b0;
            right_phase_next = 1'b0;
            if (correction_reg < CORR_LIMIT)
                diff_next = (load < SUM_MIN) ? DIFF_W'(SUM_MIN) : DIFF_W'(load);
            else
                diff_next = '0;
        end
        else
        begin
            left_phase_next  = left_phase_reg ^ left_edge;
            right_phase_next = right_phase_reg ^ right_edge;
            if (sum > SUM_MAX)
                diff_next = DIFF_W'(SUM_MAX);
            else if (sum < SUM_MIN)
                diff_next = DIFF_W'(SUM_MIN);
            else
                diff_next = DIFF_W'(sum);
            // Track distance modulo the save interval; a wrap to zero restarts it
            if (left_edge)
            begin
                dist_next = dist_inc;
                rem_next  = ((dist_inc == '0) || (rem_inc == REM_WRAP)) ? '0
                            : rem_inc[REM_W-1:0];
                save_next = (rem_next == '0);
            end
        end

        word_next = save_next ? WORD_W'({diff_next[DIFF_W-1], diff_next} + CORR_OFFSET)
                              : '0;

        // Slow the faster wheel
        if (diff_next > 0)
        begin
            left_speed_next  = SPEED_W'(DIFF_MAX - diff_next);
            right_speed_next = SPEED_FULL;
        end
        else
        begin
            left_speed_next  = SPEED_FULL;
            right_speed_next = SPEED_W'(DIFF_MAX + diff_next);
        end
    end

    // Hold control state: input stage, result stage and unit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            left_phase_reg  <= 1'b0;
            right_phase_reg <= 1'b0;
            diff_reg        <= '0;
            dist_reg        <= '0;
            rem_reg         <= '0;
        end
        else
        begin
            if (sample.ready)
                s1_valid_reg <= sample.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (fire)
            begin
                left_phase_reg  <= left_phase_next;
                right_phase_reg <= right_phase_next;
                diff_reg        <= diff_next;
                dist_reg        <= dist_next;
                rem_reg         <= rem_next;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            s1_op_reg    <= sample.operation;
            s1_left_reg  <= sample.left_level;
            s1_right_reg <= sample.right_level;
        end
        if (fire)
        begin
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
            out_diff_reg    <= diff_next;
            save_reg        <= save_next;
            word_reg        <= word_next;
        end
    end

    // Drive the result beat
    assign result.valid            = out_valid_reg;
    assign result.left_speed       = left_speed_reg;
    assign result.right_speed      = right_speed_reg;
    assign result.led_code         = {right_phase_reg, left_phase_reg};
    assign result.wheel_difference = out_diff_reg;
    assign result.save_request     = save_reg;
    assign result.save_word        = word_reg;

endmodule

// ----- hdl/wosd_checker.sv -----
// Port checker for the wheel odometry straight drive unit, with its bind.
// Depends on wosd_pkg.
module wosd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [wosd_pkg::SPEED_W-1:0]        left_speed,
    input logic [wosd_pkg::SPEED_W-1:0]        right_speed,
    input logic signed [wosd_pkg::DIFF_W-1:0]  wheel_difference,
    input logic                                save_request,
    input logic [wosd_pkg::WORD_W-1:0]         save_word
);
    import wosd_pkg::*;

    // Stalled beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // Stalled beat keeps its difference
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(wheel_difference))
        else $error("result difference changed while stalled");

    // Positive difference: left wheel slowed by the difference, right at full speed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (wheel_difference > 0) |->
            (right_speed == SPEED_FULL) && (left_speed == SPEED_W'(DIFF_MAX - wheel_difference)))
        else $error("speed does not match positive difference");

    // No save word without a save request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !save_request |-> save_word == '0)
        else $error("save word set without request");

endmodule

bind wheel_odometry_straight_drive_unit wosd_checker u_wosd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .left_speed       (result.left_speed),
    .right_speed      (result.right_speed),
    .wheel_difference (result.wheel_difference),
    .save_request     (result.save_request),
    .save_word        (result.save_word)
);
